// File: hdl/rtt_pkg.sv
// shared types, constants and decode helpers of the repeating report task timer
package rtt_pkg;

   localparam int CODE_WIDTH    = 16;
   localparam int COUNT_WIDTH   = 16;
   localparam int ELAPSED_WIDTH = 40;
   localparam int INTERVAL_WIDTH = 30;
   localparam int POINTS_WIDTH  = 14;
   localparam int RANGE_WIDTH   = 5;

   localparam logic [CODE_WIDTH-1:0] TWO_DIGIT_LOW   = 16'd10;
   localparam logic [CODE_WIDTH-1:0] TWO_DIGIT_HIGH  = 16'd99;
   localparam logic [CODE_WIDTH-1:0] FOUR_DIGIT_LOW  = 16'd1000;
   localparam logic [CODE_WIDTH-1:0] FOUR_DIGIT_HIGH = 16'd2999;
   localparam logic [CODE_WIDTH-1:0] THOUSAND_TWO    = 16'd2000;
   localparam logic [POINTS_WIDTH-1:0] BASE_POINTS   = 14'd4096;
   localparam logic [31:0] RECIP_TEN = 32'd52429;
   localparam int RECIP_SHIFT = 19;
   localparam logic [INTERVAL_WIDTH-1:0] MINUTE_US = 30'd60000000;

   typedef enum logic [2:0] {
      OP_SCHEDULE = 3'd0,
      OP_SLEEP    = 3'd1,
      OP_WORK     = 3'd2,
      OP_ATTEMPT  = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_NOP       = 3'd0,
      KIND_SCHED_OK  = 3'd1,
      KIND_SCHED_BAD = 3'd2,
      KIND_SLEEP     = 3'd3,
      KIND_WORK      = 3'd4,
      KIND_ATTEMPT   = 3'd5,
      KIND_CLEAR     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic                        elapsed_nz;
      logic [ELAPSED_WIDTH-1:0]    elapsed;
      logic [INTERVAL_WIDTH-1:0]   interval;
      logic [COUNT_WIDTH-1:0]      count;
      logic                        opt_present;
      logic [POINTS_WIDTH-1:0]     points;
      logic [RANGE_WIDTH-1:0]      range_g;
      logic                        spectrum;
   } cmd_type;

   typedef struct packed {
      logic                        accepted;
      logic                        active;
      logic                        due;
      logic [COUNT_WIDTH-1:0]      remaining;
      logic                        opt_present;
      logic [POINTS_WIDTH-1:0]     points;
      logic [RANGE_WIDTH-1:0]      range_g;
      logic                        spectrum_req;
   } status_type;

   function automatic logic [INTERVAL_WIDTH-1:0] minutes_to_us(input logic [3:0] minutes);
      logic [INTERVAL_WIDTH-1:0] us;
      case (minutes)
         4'd1:    us = MINUTE_US;
         4'd2:    us = 30'd120000000;
         4'd3:    us = 30'd180000000;
         4'd4:    us = 30'd240000000;
         4'd5:    us = 30'd300000000;
         4'd6:    us = 30'd360000000;
         4'd7:    us = 30'd420000000;
         4'd8:    us = 30'd480000000;
         4'd9:    us = 30'd540000000;
         default: us = '0;
      endcase
      return us;
   endfunction

endpackage

// File: hdl/rtt_front.sv
// front end: classifies each event and decodes schedule action codes
module rtt_front import rtt_pkg::*; #(
   parameter int TAG_WIDTH = 32
) (
   input  logic [2:0]               opcode,
   input  logic [TAG_WIDTH-1:0]     task_tag,
   input  logic [CODE_WIDTH-1:0]    action_code,
   input  logic [COUNT_WIDTH-1:0]   repeat_count,
   input  logic [ELAPSED_WIDTH-1:0] elapsed_us,
   output cmd_type                  cmd
);

   logic [31:0]            prod;
   logic [12:0]            q10;
   logic [CODE_WIDTH-1:0]  q10_times_ten;
   logic [CODE_WIDTH-1:0]  rem;
   logic [3:0]             minutes;
   logic [CODE_WIDTH-1:0]  rng;
   logic                   two_digit;
   logic                   four_digit;
   logic                   thousand_two;
   logic                   rng_ok;
   logic                   spec;
   logic                   sched_ok;

   // divide by ten through the reciprocal, exact over the decoded code ranges
   assign prod          = 32'(action_code) * RECIP_TEN;
   assign q10           = prod[31:RECIP_SHIFT];
   assign q10_times_ten = {q10[12:0], 3'b000} + {2'b00, q10[12:0], 1'b0};
   assign rem           = action_code - q10_times_ten;
   assign minutes       = rem[3:0];

   assign two_digit    = (action_code >= TWO_DIGIT_LOW) && (action_code <= TWO_DIGIT_HIGH);
   assign four_digit   = (action_code >= FOUR_DIGIT_LOW) && (action_code <= FOUR_DIGIT_HIGH);
   assign thousand_two = action_code >= THOUSAND_TWO;
   assign rng          = {3'b000, q10} - (thousand_two ? 16'd200 : 16'd100);

   always_comb begin
      rng_ok = rng inside {16'd2, 16'd4, 16'd8, 16'd16};
   end

   assign spec     = four_digit && (minutes == 4'd0);
   assign sched_ok = (task_tag != '0) && (repeat_count != '0) &&
                     ((two_digit && (minutes != 4'd0)) || (four_digit && rng_ok));

   always_comb begin
      cmd.elapsed_nz  = elapsed_us != '0;
      cmd.elapsed     = elapsed_us;
      cmd.interval    = minutes_to_us(minutes);
      cmd.count       = spec ? 16'd1 : repeat_count;
      cmd.opt_present = four_digit;
      cmd.points      = four_digit ? (thousand_two ? 14'(BASE_POINTS << 1) : BASE_POINTS) : '0;
      cmd.range_g     = four_digit ? rng[RANGE_WIDTH-1:0] : '0;
      cmd.spectrum    = spec;
      case (opcode)
         OP_SCHEDULE: cmd.kind = sched_ok ? KIND_SCHED_OK : KIND_SCHED_BAD;
         OP_SLEEP:    cmd.kind = KIND_SLEEP;
         OP_WORK:     cmd.kind = KIND_WORK;
         OP_ATTEMPT:  cmd.kind = KIND_ATTEMPT;
         OP_CLEAR:    cmd.kind = KIND_CLEAR;
         default:     cmd.kind = KIND_NOP;
      endcase
   end

endmodule

// File: hdl/rtt_fifo.sv
// short register queue between front end and back end
module rtt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/rtt_back.sv
// back end: task state, time left bookkeeping and the registered result
module rtt_back import rtt_pkg::*; #(
   parameter int TAG_WIDTH  = 32,
   parameter int TIME_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   input  logic [TAG_WIDTH-1:0]  cmd_tag,
   output logic                  out_valid,
   input  logic                  out_ready,
   output status_type            out_status,
   output logic [TIME_WIDTH-1:0] out_time_left,
   output logic [TAG_WIDTH-1:0]  out_tag
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
   localparam logic [TIME_WIDTH-1:0] TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
   localparam int SUM_W = ((TIME_WIDTH > ELAPSED_WIDTH) ? TIME_WIDTH : ELAPSED_WIDTH + 1) + 1;

   logic                      active_ff, active_in;
   logic [TAG_WIDTH-1:0]      tag_ff, tag_in;
   logic [INTERVAL_WIDTH-1:0] interval_ff, interval_in;
   logic [TIME_WIDTH-1:0]     left_ff, left_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      opt_ff, opt_in;
   logic [POINTS_WIDTH-1:0]   points_ff, points_in;
   logic [RANGE_WIDTH-1:0]    range_ff, range_in;
   logic                      spec_ff, spec_in;
   logic                      skip_ff, skip_in;

   logic                      out_valid_ff, out_valid_in;
   status_type                status_ff, status_in;
   logic [TIME_WIDTH-1:0]     time_ff, time_in;
   logic [TAG_WIDTH-1:0]      out_tag_ff, out_tag_in;

   logic                      take;
   logic                      accepted;
   logic                      charging;
   logic [SUM_W-1:0]          left_x;
   logic [SUM_W-1:0]          operand;
   logic [SUM_W-1:0]          sum;
   logic                      sum_fits;
   logic [TIME_WIDTH-1:0]     left_sat;
   logic [COUNT_WIDTH-1:0]    count_dec;

   assign cmd_ready = !out_valid_ff || out_ready;
   assign take      = cmd_valid && cmd_ready;

   // one adder serves both the charge and the reload, saturating on overflow
   assign charging = cmd.kind != KIND_ATTEMPT;
   assign left_x   = {{(SUM_W-TIME_WIDTH){left_ff[TIME_WIDTH-1]}}, left_ff};
   assign operand  = charging ? (~SUM_W'(cmd.elapsed) + 1'b1) : SUM_W'(interval_ff);
   assign sum      = left_x + operand;
   assign sum_fits = (sum[SUM_W-1:TIME_WIDTH-1] == '0) || (sum[SUM_W-1:TIME_WIDTH-1] == '1);
   assign left_sat = sum_fits ? sum[TIME_WIDTH-1:0] : (sum[SUM_W-1] ? TIME_MIN : TIME_MAX);
   assign count_dec = (count_ff == '0) ? '0 : count_ff - 1'b1;

   always_comb begin
      active_in   = active_ff;
      tag_in      = tag_ff;
      interval_in = interval_ff;
      left_in     = left_ff;
      count_in    = count_ff;
      opt_in      = opt_ff;
      points_in   = points_ff;
      range_in    = range_ff;
      spec_in     = spec_ff;
      skip_in     = skip_ff;
      accepted    = 1'b0;
      if (take) begin
         case (cmd.kind)
            KIND_SCHED_OK: begin
               accepted    = 1'b1;
               active_in   = 1'b1;
               tag_in      = cmd_tag;
               interval_in = cmd.interval;
               left_in     = TIME_WIDTH'(cmd.interval);
               count_in    = cmd.count;
               opt_in      = cmd.opt_present;
               points_in   = cmd.points;
               range_in    = cmd.range_g;
               spec_in     = cmd.spectrum;
               skip_in     = 1'b1;
            end
            KIND_SLEEP: begin
               skip_in = 1'b0;
               if (active_ff && cmd.elapsed_nz) begin
                  left_in = left_sat;
               end
            end
            KIND_WORK: begin
               if (active_ff && cmd.elapsed_nz) begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                  end else begin
                     left_in = left_sat;
                  end
               end
            end
            KIND_ATTEMPT: begin
               if (active_ff && (cmd_tag == tag_ff)) begin
                  accepted = 1'b1;
                  if (count_dec == '0) begin
                     active_in   = 1'b0;
                     tag_in      = '0;
                     interval_in = '0;
                     left_in     = '0;
                     count_in    = '0;
                     opt_in      = 1'b0;
                     points_in   = '0;
                     range_in    = '0;
                     spec_in     = 1'b0;
                     skip_in     = 1'b0;
                  end else begin
                     count_in = count_dec;
                     left_in  = left_sat;
                  end
               end
            end
            KIND_CLEAR: begin
               active_in   = 1'b0;
               tag_in      = '0;
               interval_in = '0;
               left_in     = '0;
               count_in    = '0;
               opt_in      = 1'b0;
               points_in   = '0;
               range_in    = '0;
               spec_in     = 1'b0;
               skip_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      time_in      = time_ff;
      out_tag_in   = out_tag_ff;
      if (take) begin
         out_valid_in           = 1'b1;
         status_in.accepted     = accepted;
         status_in.active       = active_in;
         status_in.due          = active_in && (count_in != '0) &&
                                  (left_in[TIME_WIDTH-1] || (left_in == '0));
         status_in.remaining    = count_in;
         status_in.opt_present  = opt_in;
         status_in.points       = points_in;
         status_in.range_g      = range_in;
         status_in.spectrum_req = spec_in;
         time_in                = active_in ? left_in : TIME_MAX;
         out_tag_in             = tag_in;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tag_ff       <= '0;
         interval_ff  <= '0;
         left_ff      <= '0;
         count_ff     <= '0;
         opt_ff       <= 1'b0;
         points_ff    <= '0;
         range_ff     <= '0;
         spec_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         tag_ff       <= tag_in;
         interval_ff  <= interval_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         opt_ff       <= opt_in;
         points_ff    <= points_in;
         range_ff     <= range_in;
         spec_ff      <= spec_in;
         skip_ff      <= skip_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      time_ff    <= time_in;
      out_tag_ff <= out_tag_in;
   end

   assign out_valid     = out_valid_ff;
   assign out_status    = status_ff;
   assign out_time_left = time_ff;
   assign out_tag       = out_tag_ff;

endmodule

// File: hdl/repeating_report_task_timer_top.sv
// top level of the repeating report task timer
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tuser opcode, tdata event fields
//   rsp_      out        rsp_tvalid/tready    tdata task status after the event
//
// one event per cycle sustained while rsp_tready stays high
// the front end decodes in the accept cycle, a two-entry queue feeds the back end,
// and the back end updates the task state and registers the result in the same cycle
// synchronous active-high reset returns the task to inactive and empties the queue
// a stalled result stops the back end only; the queue keeps taking events until full
module repeating_report_task_timer_top import rtt_pkg::*; #(
   parameter int TAG_WIDTH  = 32,
   parameter int TIME_WIDTH = 48,
   localparam int REQ_RAW_W  = TAG_WIDTH + CODE_WIDTH + COUNT_WIDTH + ELAPSED_WIDTH,
   localparam int REQ_DATA_W = ((REQ_RAW_W + 7) / 8) * 8,
   localparam int RSP_RAW_W  = 3 + TIME_WIDTH + TAG_WIDTH + COUNT_WIDTH + 1 +
                               POINTS_WIDTH + RANGE_WIDTH + 1,
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode
   input  logic [2:0]             req_tuser,
   // task_tag, action_code, repeat_count, elapsed_us, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accepted, active, due, time_left_us, current_tag, remaining, opt_present,
   // points, range_g, spectrum_req, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int QUEUE_W    = $bits(cmd_type) + TAG_WIDTH;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};

   logic [TAG_WIDTH-1:0]     in_tag;
   logic [CODE_WIDTH-1:0]    in_code;
   logic [COUNT_WIDTH-1:0]   in_count;
   logic [ELAPSED_WIDTH-1:0] in_elapsed;
   cmd_type                  front_cmd;
   logic [QUEUE_W-1:0]       q_out;
   logic                     q_valid;
   logic                     q_ready;
   cmd_type                  back_cmd;
   logic [TAG_WIDTH-1:0]     back_tag;
   status_type               status;
   logic [TIME_WIDTH-1:0]    time_left;
   logic [TAG_WIDTH-1:0]     cur_tag;

   assign in_tag     = req_tdata[TAG_WIDTH-1:0];
   assign in_code    = req_tdata[TAG_WIDTH +: CODE_WIDTH];
   assign in_count   = req_tdata[TAG_WIDTH+CODE_WIDTH +: COUNT_WIDTH];
   assign in_elapsed = req_tdata[TAG_WIDTH+CODE_WIDTH+COUNT_WIDTH +: ELAPSED_WIDTH];

   rtt_front #(
      .TAG_WIDTH (TAG_WIDTH)
   ) u_front (
      .opcode       (req_tuser),
      .task_tag     (in_tag),
      .action_code  (in_code),
      .repeat_count (in_count),
      .elapsed_us   (in_elapsed),
      .cmd          (front_cmd)
   );

   rtt_fifo #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  ({front_cmd, in_tag}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out)
   );

   assign back_cmd = q_out[QUEUE_W-1:TAG_WIDTH];
   assign back_tag = q_out[TAG_WIDTH-1:0];

   rtt_back #(
      .TAG_WIDTH  (TAG_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd           (back_cmd),
      .cmd_tag       (back_tag),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_status    (status),
      .out_time_left (time_left),
      .out_tag       (cur_tag)
   );

   assign rsp_tdata = RSP_DATA_W'({status.spectrum_req, status.range_g, status.points,
                                   status.opt_present, status.remaining, cur_tag, time_left,
                                   status.due, status.active, status.accepted});

`ifndef SYNTHESIS
   a_due_needs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status.due |-> status.active)
      else $error("due reported without an active task");

   a_idle_shows_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !status.active |-> (time_left == TIME_MAX) && (cur_tag == '0) &&
      (status.remaining == '0))
      else $error("inactive task reports stale time, tag or count");

   a_options_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !status.opt_present |-> (status.points == '0) && (status.range_g == '0))
      else $error("capture options present without a four-digit code");

   a_queue_feeds_back: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> rsp_tvalid)
      else $error("queued event produced no result");
`endif

endmodule
